// ----- src/bbw_pkg.sv -----
package bbw_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned COEFF_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned UPPER_W  = 28;
  localparam int unsigned LOWER_W  = 29;

  // Running sums hold exactly for any window up to 2^LEN_W - 1 samples
  localparam int unsigned SUM_W  = SAMPLE_W + LEN_W;       // 25
  localparam int unsigned SQ_W   = 2 * SAMPLE_W + LEN_W;   // 41
  localparam int unsigned PROD_W = 2 * SUM_W;              // 50

  // Shared divider: quotient bits, divisor and partial remainder widths
  localparam int unsigned DIVQ_W = 46;
  localparam int unsigned DIVD_W = 2 * LEN_W;              // 18
  localparam int unsigned DIVR_W = DIVD_W + 1;

  // Square root unit
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned SQR_W  = ROOT_W + 2;

  // Step counts of the iterative phases
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned VAR_STEPS  = DIVQ_W;
  localparam int unsigned ROOT_STEPS = ROOT_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COEFF    = 2'd1;

  localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST = 9'd20;
  localparam logic [COEFF_W-1:0] BAND_COEFF_RST    = 8'd32;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_READ  = 10'b00_0000_0010,
    S_UPD   = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_SUB   = 10'b00_0001_0000,
    S_DIVV  = 10'b00_0010_0000,
    S_LOAD2 = 10'b00_0100_0000,
    S_ROOT  = 10'b00_1000_0000,
    S_OFF   = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // latch the accepted sample
    logic rd;        // read the oldest delay-line entry
    logic upd;       // update sums, pointer and delay line
    logic mul;       // form n*sumsq, sum^2 and n^2
    logic sub;       // difference, load divider for the variance
    logic div_step;  // one divider step
    logic load2;     // load root unit and divider for the mean
    logic root_step; // one root step
    logic off;       // band offset
    logic load_out;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic full_next; // window full after this sample
  } status_t;

endpackage

// ----- src/bbw_datapath.sv -----
module bbw_datapath #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bbw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [bbw_pkg::SAMPLE_W-1:0]      sample_i,
  input  bbw_pkg::cmd_t                     cmd_i,
  output bbw_pkg::status_t                  status_o,
  output logic                              window_full_o,
  output logic [bbw_pkg::MEAN_W-1:0]        mean_value_o,
  output logic [bbw_pkg::UPPER_W-1:0]       upper_band_o,
  output logic signed [bbw_pkg::LOWER_W-1:0] lower_band_o
);
  import bbw_pkg::*;

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
  localparam int unsigned CMP_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  logic [LEN_W-1:0]    wl_q;
  logic [COEFF_W-1:0]  coeff_q;
  logic [PTR_W-1:0]    ptr_q, ptr_d, ptr_eff;
  logic [LEN_W-1:0]    fill_q, fill_d, n;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                full_q;
  logic                full_before;

  logic [SAMPLE_W-1:0]   smp_q, old_q;
  logic [2*SAMPLE_W-1:0] ssq_q, old_sq;
  logic [SAMPLE_W-1:0]   hist_mem [MAX_WINDOW];

  logic [PROD_W-1:0] prod_a_q, prod_b_q, diff;
  logic [DIVD_W-1:0] n2_q, div_d_q;
  logic [DIVR_W-1:0] div_r_q, div_t;
  logic [DIVQ_W-1:0] div_x_q;
  logic              div_bit;

  logic [RAD_W-1:0]  sq_x_q;
  logic [SQR_W-1:0]  sq_r_q;
  logic [ROOT_W-1:0] sq_y_q;
  logic [SQR_W+1:0]  rt_t, rt_trial;
  logic              rt_bit;

  logic [UPPER_W-1:0]               off_q;
  logic [COEFF_W+ROOT_W-1:0]        off_prod;
  logic [MEAN_W-1:0]                mean_res;

  // Square of the sample leaving the window
  assign old_sq = old_q * old_q;

  // Effective window length
  always_comb begin
    if (wl_q == '0) begin
      n = LEN_W'(1);
    end else if (32'(wl_q) > MAX_WINDOW) begin
      n = LEN_W'(MAX_WINDOW);
    end else begin
      n = wl_q;
    end
  end

  // Pointer wrap and fill tracking
  always_comb begin
    ptr_eff = (CMP_W'(ptr_q) >= CMP_W'(n)) ? '0 : ptr_q;
    ptr_d   = (CMP_W'(ptr_eff) + CMP_W'(1) >= CMP_W'(n)) ? '0 : ptr_eff + PTR_W'(1);
    full_before = (fill_q >= n);
    fill_d  = full_before ? n : fill_q + LEN_W'(1);
    sum_d   = sum_q + SUM_W'(smp_q);
    sq_d    = sq_q + SQ_W'(ssq_q);
    if (full_before) begin
      sum_d = sum_d - SUM_W'(old_q);
      sq_d  = sq_d - SQ_W'(old_sq);
    end
  end

  assign status_o.full_next = (fill_d >= n);

  // Configuration registers and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= WINDOW_LENGTH_RST;
      coeff_q <= BAND_COEFF_RST;
      ptr_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      full_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WINDOW_LENGTH) begin
        wl_q   <= cfg_data_i[LEN_W-1:0];
        ptr_q  <= '0;
        fill_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end else if (cfg_index_i == CFG_BAND_COEFF) begin
        coeff_q <= cfg_data_i[COEFF_W-1:0];
      end
    end else if (cmd_i.upd) begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
      sq_q   <= sq_d;
      full_q <= status_o.full_next;
    end
  end

  // Delay line
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      old_q <= hist_mem[ptr_eff];
    end
    if (cmd_i.upd) begin
      hist_mem[ptr_eff] <= smp_q;
    end
  end

  // Divider and root step logic
  always_comb begin
    div_t   = {div_r_q[DIVR_W-2:0], div_x_q[DIVQ_W-1]};
    div_bit = (div_t >= DIVR_W'(div_d_q));
    if (div_bit) begin
      div_t = div_t - DIVR_W'(div_d_q);
    end
    rt_t     = {sq_r_q, sq_x_q[RAD_W-1 -: 2]};
    rt_trial = (SQR_W+2)'({sq_y_q, 2'b01});
    rt_bit   = (rt_t >= rt_trial);
    if (rt_bit) begin
      rt_t = rt_t - rt_trial;
    end
    diff     = (prod_a_q > prod_b_q) ? prod_a_q - prod_b_q : '0;
    off_prod = coeff_q * sq_y_q;
    mean_res = div_x_q[MEAN_W-1:0];
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      smp_q <= sample_i;
    end
    if (cmd_i.rd) begin
      ssq_q <= smp_q * smp_q;
    end
    if (cmd_i.mul) begin
      prod_a_q <= n * PROD_W'(sq_q);
      prod_b_q <= sum_q * sum_q;
      n2_q     <= n * n;
    end
    if (cmd_i.sub) begin
      // variance quotient fits DIVQ_W bits, so the top part is below n^2
      div_d_q <= n2_q;
      div_r_q <= DIVR_W'(diff >> (DIVQ_W - 16));
      div_x_q <= {diff[DIVQ_W-17:0], 16'b0};
    end else if (cmd_i.load2) begin
      div_d_q <= DIVD_W'(n);
      div_r_q <= DIVR_W'(sum_q >> 16);
      div_x_q <= {sum_q[15:0], 8'b0, (DIVQ_W-MEAN_W)'(0)};
    end else if (cmd_i.div_step) begin
      div_r_q <= div_t;
      div_x_q <= {div_x_q[DIVQ_W-2:0], div_bit};
    end
    if (cmd_i.load2) begin
      sq_x_q <= RAD_W'(div_x_q);
      sq_r_q <= '0;
      sq_y_q <= '0;
    end else if (cmd_i.root_step) begin
      sq_x_q <= {sq_x_q[RAD_W-3:0], 2'b00};
      sq_r_q <= SQR_W'(rt_t);
      sq_y_q <= {sq_y_q[ROOT_W-2:0], rt_bit};
    end
    if (cmd_i.off) begin
      off_q <= UPPER_W'(off_prod >> 4);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      window_full_o <= full_q;
      if (full_q) begin
        mean_value_o <= mean_res;
        upper_band_o <= UPPER_W'(mean_res) + off_q;
        lower_band_o <= signed'(LOWER_W'(mean_res) - LOWER_W'(off_q));
      end else begin
        mean_value_o <= '0;
        upper_band_o <= '0;
        lower_band_o <= '0;
      end
    end
  end

endmodule

// ----- src/bbw_ctrl.sv -----
module bbw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  bbw_pkg::status_t status_i,
  output bbw_pkg::cmd_t    cmd_o
);
  import bbw_pkg::*;

  state_e           st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          st_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        st_d     = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        st_d      = status_i.full_next ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        st_d      = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        cnt_d     = CNT_W'(VAR_STEPS - 1);
        st_d      = S_DIVV;
      end
      S_DIVV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          st_d = S_LOAD2;
        end
      end
      S_LOAD2: begin
        cmd_o.load2 = 1'b1;
        cnt_d       = CNT_W'(ROOT_STEPS - 1);
        st_d        = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          st_d = S_OFF;
        end
      end
      S_OFF: begin
        cmd_o.off = 1'b1;
        st_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          st_d           = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == S_READ)
    else $error("accepted sample did not start a delay-line read");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_FIN))
    else $error("result raised outside the finish state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");
`endif

endmodule

// ----- src/bollinger_band_window.sv -----
// Bollinger band window: takes one 16-bit price sample per transfer and returns one
// result per sample: window-full flag, moving mean and upper/lower bands, all with
// 8 fractional bits. While the window is filling a sample gives zeros; once full the
// result comes from the shared shift-subtract divider (46 steps for the variance,
// then 24 steps for the mean run alongside the 24-step square root). A finished
// result waits in the output register while the next sample is accepted. Writing
// window_length restarts the window.
module bollinger_band_window #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bbw_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               window_full_o,
  output logic [bbw_pkg::MEAN_W-1:0]         mean_value_o,
  output logic [bbw_pkg::UPPER_W-1:0]        upper_band_o,
  output logic signed [bbw_pkg::LOWER_W-1:0] lower_band_o
);
  import bbw_pkg::*;

  cmd_t    cmd;
  status_t status;

  bbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bbw_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .window_full_o (window_full_o),
    .mean_value_o  (mean_value_o),
    .upper_band_o  (upper_band_o),
    .lower_band_o  (lower_band_o)
  );

endmodule

// ----- tb/bollinger_band_window_tb.sv -----
`timescale 1ns / 100ps

module bollinger_band_window_tb;
  import bbw_pkg::*;

  localparam int unsigned HIST_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic                      full;
    logic [MEAN_W-1:0]         mean;
    logic [UPPER_W-1:0]        upper;
    logic signed [LOWER_W-1:0] lower;
  } band_result_t;

  // Pending work for the driver: either a sample or a register write
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   sample;
  } job_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  window_full_o;
  logic [MEAN_W-1:0]     mean_value_o;
  logic [UPPER_W-1:0]    upper_band_o;
  logic signed [LOWER_W-1:0] lower_band_o;

  bollinger_band_window dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .sample_i(sample_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .window_full_o(window_full_o), .mean_value_o(mean_value_o),
    .upper_band_o(upper_band_o), .lower_band_o(lower_band_o)
  );

  // Shadow of the band computation
  logic [SAMPLE_W-1:0] price_hist [HIST_DEPTH];
  int unsigned hist_ptr, hist_fill;
  logic [63:0] price_sum, price_sq_sum;
  logic [LEN_W-1:0]   win_len_reg;
  logic [COEFF_W-1:0] coeff_reg;

  job_t         job_q [$];
  band_result_t band_q [$];
  int unsigned  n_err, n_results, n_samples, n_cfg, cycles;
  bit           stim_done;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned eff_len();
    if (win_len_reg == 0) return 1;
    if (win_len_reg > HIST_DEPTH) return HIST_DEPTH;
    return 32'(win_len_reg);
  endfunction

  task automatic predict_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    if (idx == CFG_WINDOW_LENGTH) begin
      win_len_reg = d[LEN_W-1:0];
      hist_ptr = 0; hist_fill = 0; price_sum = 0; price_sq_sum = 0;
    end else if (idx == CFG_BAND_COEFF) begin
      coeff_reg = d[COEFF_W-1:0];
    end
  endtask

  // Rolling-window update and band calculation for one accepted sample
  task automatic predict_bands(input logic [SAMPLE_W-1:0] s);
    int unsigned n, p;
    logic [63:0] old, nn, mean, a, b, d, q, r, var_v, sd, offs;
    band_result_t res;
    n = eff_len();
    p = (hist_ptr >= n) ? 0 : hist_ptr;
    if (hist_fill >= n) begin
      old = 64'(price_hist[p]);
      price_sum -= old;
      price_sq_sum -= old * old;
      hist_fill = n;
    end else begin
      hist_fill++;
    end
    price_hist[p] = s;
    price_sum += 64'(s);
    price_sq_sum += 64'(s) * 64'(s);
    p++;
    hist_ptr = (p >= n) ? 0 : p;
    res = '0;
    if (hist_fill >= n) begin
      nn = 64'(n);
      mean = (price_sum << 8) / nn;
      a = nn * price_sq_sum;
      b = price_sum * price_sum;
      d = (a > b) ? a - b : 0;
      q = d / (nn * nn);
      r = d % (nn * nn);
      var_v = (q << 16) + ((r << 16) / (nn * nn));
      sd = int_sqrt(var_v);
      offs = (64'(coeff_reg) * sd) >> 4;
      res.full = 1'b1;
      res.mean = mean[MEAN_W-1:0];
      res.upper = UPPER_W'(mean + offs);
      res.lower = LOWER_W'(mean - offs);
    end
    band_q.push_back(res);
  endtask

  // Driver: register writes go out only once the block has drained
  int unsigned drv_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    bit cfg_go;
    cfg_go = 1'b0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i <= '0;
      cfg_we_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      drv_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_bands(sample_i);
        n_samples++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transfer
      end else if (drv_wait > 0) begin
        in_valid_i <= 1'b0;
        drv_wait--;
      end else if (job_q.size() > 0 && job_q[0].is_cfg) begin
        in_valid_i <= 1'b0;
        if (band_q.size() == 0 && !(in_valid_i)) begin
          cfg_go = 1'b1;
          cfg_index_i <= job_q[0].idx;
          cfg_data_i <= job_q[0].data;
          predict_cfg(job_q[0].idx, job_q[0].data);
          n_cfg++;
          void'(job_q.pop_front());
          drv_wait = 2;
        end
      end else if (job_q.size() > 0) begin
        in_valid_i <= 1'b1;
        sample_i <= job_q[0].sample;
        void'(job_q.pop_front());
        drv_wait = gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
      cfg_we_i <= cfg_go;
    end
  end

  // Monitor and receiver back-pressure
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    band_result_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (band_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          exp_r = band_q.pop_front();
          if (window_full_o !== exp_r.full || mean_value_o !== exp_r.mean ||
              upper_band_o !== exp_r.upper || lower_band_o !== exp_r.lower) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: full %0d/%0d mean %0d/%0d upper %0d/%0d lower %0d/%0d",
                       window_full_o, exp_r.full, mean_value_o, exp_r.mean,
                       upper_band_o, exp_r.upper, lower_band_o, exp_r.lower);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  task automatic add_sample(input logic [SAMPLE_W-1:0] s);
    job_q.push_back('{is_cfg: 1'b0, idx: '0, data: '0, sample: s});
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    job_q.push_back('{is_cfg: 1'b1, idx: idx, data: d, sample: '0});
  endtask

  // Random samples: mostly near a level fixed for the run, some full-range noise
  task automatic add_random_run(input int unsigned count);
    int unsigned level;
    level = $urandom_range(0, 65535);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) add_sample(SAMPLE_W'($urandom_range(0, 65535)));
      else add_sample(SAMPLE_W'(level + $urandom_range(0, 2047)));
    end
  endtask

  initial begin
    int unsigned len, remaining, run;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    n_err = 0; n_results = 0; n_samples = 0; n_cfg = 0; cycles = 0;
    stim_done = 1'b0;
    win_len_reg = WINDOW_LENGTH_RST;
    coeff_reg = BAND_COEFF_RST;
    hist_ptr = 0; hist_fill = 0; price_sum = 0; price_sq_sum = 0;
    foreach (price_hist[i]) price_hist[i] = '0;

    // Directed: reset window of 20, extreme values, length 1, zero length
    repeat (20) add_sample(16'hFFFF);
    add_sample(16'h0000);
    add_cfg(CFG_WINDOW_LENGTH, 9'd1);
    add_sample(16'h0000);
    add_sample(16'hFFFF);
    add_cfg(CFG_WINDOW_LENGTH, 9'd0);
    add_cfg(CFG_BAND_COEFF, 9'h0FF);
    add_sample(16'h1234);
    add_cfg(CFG_WINDOW_LENGTH, 9'd2);
    add_sample(16'h0000);
    add_sample(16'hFFFF);
    add_sample(16'h0000);
    add_cfg(CFG_BAND_COEFF, 9'd0);
    add_sample(16'hFFFF);
    add_cfg(CFG_BAND_COEFF, 9'h0FF);
    add_cfg(CFG_WINDOW_LENGTH, 9'h1FF);  // saturates to the full depth
    add_random_run(4);
    add_cfg(CFG_WINDOW_LENGTH, 9'd3);
    add_sample(16'hFFFF); add_sample(16'h0000); add_sample(16'h0000); add_sample(16'hFFFF);

    // Random phases, a few at the largest window
    remaining = 800;
    while (remaining > 0) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(256, 511);
        1: len = $urandom_range(0, 2);
        default: len = $urandom_range(3, 40);
      endcase
      add_cfg(CFG_WINDOW_LENGTH, CFG_DATA_W'(len));
      add_cfg(CFG_BAND_COEFF, CFG_DATA_W'($urandom_range(0, 255)));
      run = (len >= 256) ? 300 : $urandom_range(10, 80);
      if (run > remaining) run = remaining;
      add_random_run(run);
      remaining -= run;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (job_q.size() == 0 && !in_valid_i);
    wait (band_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d samples over %0d register writes, %0d results checked",
             n_samples, n_cfg, n_results);
    if (n_err == 0) $display("bollinger_band_window_tb OK");
    else begin
      $display("%0d mismatches", n_err);
      $display("bollinger_band_window_tb NOT OK");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", band_q.size());
      $display("bollinger_band_window_tb NOT OK");
      $finish;
    end
  end

endmodule
